// ===== rtl/core/lerw_pkg.sv =====
`timescale 1ns / 1ps
package lerw_pkg;

  // Field widths
  localparam int CMD_W      = 1;
  localparam int JUMP_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int HEAD_W     = 13;
  localparam int LEN_W      = 13;
  localparam int STEPS_W    = 32;
  localparam int MASK_W     = 13;
  localparam int HW_W       = 13;
  localparam int CAND_W     = JUMP_W + 2;

  // out_tdata layout, lowest field first
  localparam int HEAD_LSB   = 0;
  localparam int LEN_LSB    = HEAD_LSB + HEAD_W;
  localparam int STEPS_LSB  = LEN_LSB + LEN_W;
  localparam int MASK_LSB   = STEPS_LSB + STEPS_W;
  localparam int OUT_BITS   = MASK_LSB + MASK_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int FIRST_THRESHOLD = 8;

  localparam logic [HW_W-1:0] HW_RESET = 13'd4096;

  typedef logic [STATUS_W-1:0] status_t;

  localparam logic [CMD_W-1:0] CMD_START = 1'b0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 1'b1;

  localparam status_t STATUS_RUN     = 2'd0;
  localparam status_t STATUS_ESCAPE  = 2'd1;
  localparam status_t STATUS_IGNORED = 2'd2;

endpackage

// ===== rtl/core/lerw_thresh.sv =====
`timescale 1ns / 1ps
module lerw_thresh #(
  parameter int NUM_THRESHOLDS = 13,
  parameter int DW             = 17
) (
  input  logic [DW-1:0]             reach,
  input  logic [DW-1:0]             limit,
  input  logic [NUM_THRESHOLDS-1:0] recorded,
  output logic [NUM_THRESHOLDS-1:0] fresh
);

  // threshold k is 8 << k; fresh when not yet recorded and no greater than both reach and limit
  always_comb begin
    logic [DW-1:0] t;
    fresh = '0;
    for (int k = 0; k < NUM_THRESHOLDS; k++) begin
      t = DW'(lerw_pkg::FIRST_THRESHOLD) << k;
      fresh[k] = !recorded[k] && (t <= reach) && (t <= limit);
    end
  end

endmodule

// ===== rtl/core/loop_erased_walk_step_top.sv =====
`timescale 1ns / 1ps
// One-dimensional loop-erased walk engine.
// in_*  : one request per command. in_tuser = command (0 start, 1 step),
//         in_tdata = signed 32-bit jump.
// cfg_* : writes the half width (escape limit); always ready, write only
//         while no request is in flight.
// out_* : one result per request. out_tuser = status, out_tdata holds head,
//         path length, total steps and the newly crossed threshold mask.
// The result is registered: a request passes the index-map read, the stack
// read and write-back before out_tvalid rises. A new request is taken only
// after the last one has been written back, set by the two dependent memory
// reads (position index map, then path stack) and the write-back after them.
// Reset: all 2 * MAX_HALF_WIDTH index map entries (8192 at the default) are
// swept once, with in_tready low. The walk then waits for a start; steps
// before it report the ignored status.
// Stall: a result waits in the output register; one more request may be
// taken meanwhile and then holds in write-back until the result is taken.
module loop_erased_walk_step_top #(
  parameter int MAX_HALF_WIDTH = 4096,
  parameter int NUM_THRESHOLDS = 13
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // slave side
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lerw_pkg::CMD_W-1:0]      in_tuser,   // [0] command
  input  logic [lerw_pkg::JUMP_W-1:0]     in_tdata,   // [31:0] jump
  // master side
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lerw_pkg::STATUS_W-1:0]   out_tuser,  // [1:0] status
  // [12:0] head_position, [25:13] path_length, [57:26] total_steps,
  // [70:58] crossed_mask, [71] zero
  output logic [lerw_pkg::OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lerw_pkg::HW_W-1:0]       cfg_data    // half_width
);

  localparam int MAP_DEPTH = 2 * MAX_HALF_WIDTH;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int PW        = $clog2(MAX_HALF_WIDTH) + 1;
  localparam int LW        = $clog2(MAX_HALF_WIDTH + 1);
  localparam int TW        = NUM_THRESHOLDS + 4;
  localparam int DW0       = (PW > LW) ? PW : LW;
  localparam int DW        = (DW0 > TW) ? DW0 : TW;
  localparam int HCW       = ((lerw_pkg::HW_W > LW) ? lerw_pkg::HW_W : LW) + 1;
  localparam int CW        = lerw_pkg::CAND_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_WB    = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic [lerw_pkg::HW_W-1:0] hw_r;

  // request held through the pipeline
  logic [lerw_pkg::CMD_W-1:0] cmd_r;
  logic                       esc_r;
  logic signed [PW-1:0]       pos_r;
  logic [AW-1:0]              map_addr_r;

  // walk state
  logic signed [PW-1:0]            head_r, head_nxt;
  logic [AW-1:0]                   top_r, top_nxt;
  logic [lerw_pkg::STEPS_W-1:0]    steps_r, steps_nxt;
  logic [NUM_THRESHOLDS-1:0]       rec_r, rec_nxt;
  logic                            ended_r, ended_nxt;

  // memories: position -> stack index, and the path stack itself
  logic [AW-1:0] idx_mem [MAP_DEPTH];
  logic [PW-1:0] stk_mem [MAP_DEPTH];
  logic [AW-1:0] idx_rd_r;
  logic [PW-1:0] stk_rd_r;

  logic          idx_we, stk_we;
  logic [AW-1:0] idx_wa, idx_wd, stk_wa;
  logic [PW-1:0] stk_wd;

  // output register
  logic                              out_valid_r;
  lerw_pkg::status_t                 out_status_r, status_nxt;
  logic [lerw_pkg::OUT_DATA_W-1:0]   out_data_r;

  logic accept, wb_go;

  // effective limit: half width clamped into 1..MAX_HALF_WIDTH
  logic [HCW-1:0] hw_ext;
  logic [LW-1:0]  limit;

  always_comb begin
    hw_ext = HCW'(hw_r);
    if (hw_ext == '0) begin
      limit = LW'(1);
    end else if (hw_ext > HCW'(MAX_HALF_WIDTH)) begin
      limit = LW'(MAX_HALF_WIDTH);
    end else begin
      limit = LW'(hw_ext);
    end
  end

  // candidate head
  logic signed [CW-1:0] head_ext, jump_ext, cand, lim_s;
  logic                 esc;
  logic [AW-1:0]        map_addr;

  assign head_ext = {{(CW-PW){head_r[PW-1]}}, head_r};
  assign jump_ext = {{(CW-lerw_pkg::JUMP_W){in_tdata[lerw_pkg::JUMP_W-1]}}, in_tdata};
  assign cand     = head_ext + jump_ext;
  assign lim_s    = $signed({{(CW-LW){1'b0}}, limit});
  assign esc      = (cand <= -lim_s) || (cand >= lim_s);
  // in-range positions map to pos + MAX_HALF_WIDTH
  assign map_addr = cand[AW-1:0] + AW'(MAX_HALF_WIDTH);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign wb_go     = (state_r == S_WB) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= lerw_pkg::HW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hw_r <= cfg_data;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAP_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_WB;
      S_WB: begin
        if (wb_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_tuser;
      esc_r      <= esc;
      pos_r      <= cand[PW-1:0];
      map_addr_r <= map_addr;
    end
  end

  // write-back decision
  logic                      hit;
  logic [AW-1:0]             top_inc;
  logic [PW-1:0]             abs_pos;
  logic [DW-1:0]             th_dist;
  logic [NUM_THRESHOLDS-1:0] fresh, fresh_out;

  // on the path iff its stored index is live and the stack agrees
  assign hit     = (idx_rd_r <= top_r) && ($signed(stk_rd_r) == pos_r);
  assign top_inc = top_r + 1'b1;
  assign abs_pos = pos_r[PW-1] ? (~pos_r + 1'b1) : pos_r;
  assign th_dist = esc_r ? DW'(limit) : DW'(abs_pos);

  lerw_thresh #(
    .NUM_THRESHOLDS (NUM_THRESHOLDS),
    .DW             (DW)
  ) u_thresh (
    .reach    (th_dist),
    .limit    (DW'(limit)),
    .recorded (rec_r),
    .fresh    (fresh)
  );

  always_comb begin
    head_nxt   = head_r;
    top_nxt    = top_r;
    steps_nxt  = steps_r;
    rec_nxt    = rec_r;
    ended_nxt  = ended_r;
    status_nxt = lerw_pkg::STATUS_RUN;
    fresh_out  = '0;
    stk_we     = 1'b0;
    stk_wa     = top_inc;
    stk_wd     = pos_r;
    idx_we     = 1'b0;
    idx_wa     = map_addr_r;
    idx_wd     = top_inc;
    if (state_r == S_CLEAR) begin
      idx_we = 1'b1;
      idx_wa = clr_addr_r;
      idx_wd = '0;
    end else if (wb_go) begin
      if (cmd_r == lerw_pkg::CMD_START) begin
        head_nxt  = '0;
        top_nxt   = '0;
        steps_nxt = '0;
        rec_nxt   = '0;
        ended_nxt = 1'b0;
        stk_we    = 1'b1;
        stk_wa    = '0;
        stk_wd    = '0;
        idx_we    = 1'b1;
        idx_wa    = AW'(MAX_HALF_WIDTH);
        idx_wd    = '0;
      end else if (ended_r) begin
        status_nxt = lerw_pkg::STATUS_IGNORED;
      end else if (esc_r) begin
        status_nxt = lerw_pkg::STATUS_ESCAPE;
        ended_nxt  = 1'b1;
        fresh_out  = fresh;
        rec_nxt    = rec_r | fresh;
      end else begin
        head_nxt = pos_r;
        if (hit) begin
          top_nxt = idx_rd_r;
        end else begin
          top_nxt = top_inc;
          stk_we  = 1'b1;
          idx_we  = 1'b1;
        end
        if (steps_r != '1) steps_nxt = steps_r + 1'b1;
        fresh_out = fresh;
        rec_nxt   = rec_r | fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      top_r   <= '0;
      steps_r <= '0;
      rec_r   <= '0;
      ended_r <= 1'b1;
    end else if (wb_go) begin
      head_r  <= head_nxt;
      top_r   <= top_nxt;
      steps_r <= steps_nxt;
      rec_r   <= rec_nxt;
      ended_r <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (idx_we) idx_mem[idx_wa] <= idx_wd;
    if (accept) idx_rd_r <= idx_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (state_r == S_READ) stk_rd_r <= stk_mem[idx_rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_status_r <= status_nxt;
      out_data_r   <= {{(lerw_pkg::OUT_DATA_W - lerw_pkg::OUT_BITS){1'b0}},
                       lerw_pkg::MASK_W'(fresh_out),
                       steps_nxt,
                       lerw_pkg::LEN_W'(top_nxt),
                       lerw_pkg::HEAD_W'(head_nxt)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/lerw_check.sv =====
`timescale 1ns / 1ps
module lerw_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [lerw_pkg::CMD_W-1:0]      in_tuser,
  input logic [lerw_pkg::JUMP_W-1:0]     in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lerw_pkg::STATUS_W-1:0]   out_tuser,
  input logic [lerw_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [lerw_pkg::HW_W-1:0]       cfg_data
);

  logic [lerw_pkg::LEN_W-1:0]   len;
  logic [lerw_pkg::STEPS_W-1:0] steps;
  logic [lerw_pkg::MASK_W-1:0]  mask;

  assign len   = out_tdata[lerw_pkg::LEN_LSB +: lerw_pkg::LEN_W];
  assign steps = out_tdata[lerw_pkg::STEPS_LSB +: lerw_pkg::STEPS_W];
  assign mask  = out_tdata[lerw_pkg::MASK_LSB +: lerw_pkg::MASK_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a request keeps the engine busy, so none is taken back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken in consecutive cycles");

  a_ignored_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == lerw_pkg::STATUS_IGNORED) |-> mask == '0)
    else $error("ignored step reports crossed thresholds");

  // every path entry was pushed by a counted step
  a_len_le_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> lerw_pkg::STEPS_W'(len) <= steps)
    else $error("path longer than step count");

endmodule

bind loop_erased_walk_step_top lerw_check u_lerw_check (.*);
